// File: hdl/dcfi_pkg.sv
package dcfi_pkg;

  // Store geometry
  localparam int CELL_INDEX_BITS = 16;
  localparam int ROW_ID_BITS     = 20;
  localparam int PAIR_BITS       = CELL_INDEX_BITS - 1;
  localparam int CLR_BITS        = (PAIR_BITS > ROW_ID_BITS) ? PAIR_BITS : ROW_ID_BITS;

  // Request fields
  localparam int ADDR_W     = 34;
  localparam int BANK_LSB   = 14;
  localparam int BANK_W     = 4;
  localparam int ROW_LSB    = 18;
  localparam int ROW_W      = 16;
  localparam int S_TDATA_W  = 40;
  localparam int M_TDATA_W  = 8;

  // Configuration
  localparam int PROB_W     = 20;
  localparam int THR_W      = 8;
  localparam int SEED_W     = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // Activation counters
  localparam int CNT_W = 8;
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  // Random source: Galois LFSR, draws reduced mod 1e6 = 64 * 15625
  localparam logic [SEED_W-1:0] LFSR_TAPS = 32'h8020_0003;
  localparam int PPM_W       = 20;
  localparam int PPM_LO      = 6;
  localparam int PPM_Y_W     = SEED_W - PPM_LO;
  localparam int PPM_ODD     = 15625;
  localparam int RECIP_W     = 19;
  localparam logic [RECIP_W-1:0] PPM_RECIP = 19'd274877;
  localparam int RECIP_SHIFT = 32;
  localparam int PROD_W      = PPM_Y_W + RECIP_W;
  localparam int PPM_Q_W     = 13;
  localparam int PPM_R_W     = 15;

  // Draw window
  localparam int GEN_LANES = 4;
  localparam int WIN_DEPTH = 16;
  localparam int WIN_CNT_W = $clog2(WIN_DEPTH + 1);
  localparam int WIN_W     = WIN_DEPTH * PPM_W;
  localparam int SH_W      = $clog2(WIN_W + 1);
  localparam int DRAW_MAX  = 6;
  localparam int POP_W     = $clog2(DRAW_MAX + 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_STUCK       = 3'd0,
    REG_READ_DEST   = 3'd1,
    REG_DECEPTIVE   = 3'd2,
    REG_INCORRECT   = 3'd3,
    REG_WRITE_DEST  = 3'd4,
    REG_COUPLING    = 3'd5,
    REG_HAMMER_THR  = 3'd6,
    REG_SEED        = 3'd7
  } cfg_reg_e;

  typedef enum logic [3:0] {
    FLT_NONE       = 4'd0,
    FLT_STUCK      = 4'd1,
    FLT_READ_DEST  = 4'd2,
    FLT_INCORRECT  = 4'd3,
    FLT_WRITE_DEST = 4'd4,
    FLT_TRANSITION = 4'd5,
    FLT_IDEMPOTENT = 4'd6,
    FLT_STATIC     = 4'd7,
    FLT_DISTURB    = 4'd8,
    FLT_HAMMER     = 4'd9
  } fault_t;

  typedef logic [PPM_W-1:0] ppm_t;
  typedef ppm_t [DRAW_MAX-1:0] draws_t;

  typedef struct packed {
    logic [PROB_W-1:0] p_stuck;
    logic [PROB_W-1:0] p_read_dest;
    logic [PROB_W-1:0] p_deceptive;
    logic [PROB_W-1:0] p_incorrect;
    logic [PROB_W-1:0] p_write_dest;
    logic [PROB_W-1:0] p_coupling;
    logic [THR_W-1:0]  hammer_thr;
  } cfg_t;

  typedef struct packed {
    logic              load;
    logic [SEED_W-1:0] seed;
    logic [POP_W-1:0]  pops;
  } rng_ctl_t;

  typedef struct packed {
    logic op;
    logic wbit;
    logic sel;
  } access_t;

  typedef struct packed {
    fault_t           code;
    logic [1:0]       pair;
    logic [CNT_W-1:0] cnt;
    logic [POP_W-1:0] pops;
  } result_t;

  function automatic logic [SEED_W-1:0] lfsr_step(input logic [SEED_W-1:0] s);
    logic [SEED_W-1:0] n;
    n = s >> 1;
    if (s[0]) begin
      n = n ^ LFSR_TAPS;
    end
    return n;
  endfunction

  // Row id: bank above row, truncated to the counter store depth
  function automatic logic [ROW_ID_BITS-1:0] row_id(input logic [ADDR_W-1:0] a);
    logic [BANK_W+ROW_W-1:0] full;
    full = {a[BANK_LSB +: BANK_W], a[ROW_LSB +: ROW_W]};
    return full[ROW_ID_BITS-1:0];
  endfunction

endpackage

// File: hdl/dram_cell_fault_injector.sv
// Channel   Dir  Fields (low bit up)                       Handshake
// s_*       in   tuser: operation; tdata: address, write_bit  tvalid/tready
// m_*       out  tdata: fault_code                           tvalid/tready
// cfg_*     in   index selects register, data low bits used  cfg_we, no wait
//
// Request to result: memory read, then decide and write back.
// Sustained: one request per cycle while twelve draws wait in the window and m_*
// is not stalled; the generator adds four draws per launch, but its 16-draw credit
// also counts the draws in flight, so six-draw requests run slower.
// Reset: counter and cell stores are swept to zero, s_tready low meanwhile;
// configuration writes are taken throughout.
// A stalled m_* holds its result; one more request can sit in the decide stage.
module dram_cell_fault_injector import dcfi_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [S_TDATA_W-1:0]  s_tdata,   // [33:0] address, [34] write_bit
  input  logic                  s_tuser,   // [0] operation
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [M_TDATA_W-1:0]  m_tdata,   // [3:0] fault_code
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t                   cfg;
  rng_ctl_t               rng_ctl;
  draws_t                 draws;
  logic [WIN_CNT_W-1:0]   win_count;
  result_t                res;
  access_t                acc;

  logic                   clearing;
  logic [CLR_BITS-1:0]    clr_cnt;

  logic                   in_req, out_free, s1_fire;
  logic [ADDR_W-1:0]      in_addr;

  logic                   s1_valid, s1_op, s1_wbit;
  logic [CELL_INDEX_BITS-1:0] s1_idx;
  logic [ROW_ID_BITS-1:0] s1_rid;
  logic [PAIR_BITS-1:0]   s1_pair_addr;

  logic                   cell_we, row_we;
  logic [PAIR_BITS-1:0]   cell_waddr;
  logic [1:0]             cell_wdata, cell_rdata, pair_cur;
  logic [ROW_ID_BITS-1:0] row_waddr;
  logic [CNT_W-1:0]       row_wdata, row_rdata, cnt_cur;

  logic                   cw_valid, rw_valid;
  logic [PAIR_BITS-1:0]   cw_addr;
  logic [1:0]             cw_data;
  logic [ROW_ID_BITS-1:0] rw_addr;
  logic [CNT_W-1:0]       rw_data;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.p_stuck      <= PROB_W'(10000);
      cfg.p_read_dest  <= PROB_W'(10000);
      cfg.p_deceptive  <= PROB_W'(10000);
      cfg.p_incorrect  <= PROB_W'(10000);
      cfg.p_write_dest <= PROB_W'(10000);
      cfg.p_coupling   <= PROB_W'(50000);
      cfg.hammer_thr   <= THR_W'(5);
    end else if (cfg_we) begin
      unique case (cfg_reg_e'(cfg_index))
        REG_STUCK:      cfg.p_stuck      <= cfg_data[PROB_W-1:0];
        REG_READ_DEST:  cfg.p_read_dest  <= cfg_data[PROB_W-1:0];
        REG_DECEPTIVE:  cfg.p_deceptive  <= cfg_data[PROB_W-1:0];
        REG_INCORRECT:  cfg.p_incorrect  <= cfg_data[PROB_W-1:0];
        REG_WRITE_DEST: cfg.p_write_dest <= cfg_data[PROB_W-1:0];
        REG_COUPLING:   cfg.p_coupling   <= cfg_data[PROB_W-1:0];
        REG_HAMMER_THR: cfg.hammer_thr   <= cfg_data[THR_W-1:0];
        REG_SEED: ;
        default: ;
      endcase
    end
  end

  // draw source
  assign rng_ctl.load = cfg_we && (cfg_index == REG_SEED);
  assign rng_ctl.seed = cfg_data[SEED_W-1:0];
  assign rng_ctl.pops = s1_fire ? res.pops : '0;

  dcfi_rng u_rng (
    .clk       (clk),
    .rst       (rst),
    .ctl       (rng_ctl),
    .draws     (draws),
    .win_count (win_count)
  );

  // clearing sweep after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_cnt  <= '0;
    end else if (clearing) begin
      clr_cnt <= clr_cnt + CLR_BITS'(1);
      if (clr_cnt == '1) begin
        clearing <= 1'b0;
      end
    end
  end

  // request side: enough draws must be waiting for the worst case
  assign out_free = !m_tvalid || m_tready;
  assign s1_fire  = s1_valid && out_free;
  assign s_tready = !clearing &&
                    (s1_valid ? (out_free && win_count >= WIN_CNT_W'(2 * DRAW_MAX))
                              : (win_count >= WIN_CNT_W'(DRAW_MAX)));
  assign in_req   = s_tvalid && s_tready;
  assign in_addr  = s_tdata[ADDR_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_req) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_req) begin
      s1_op   <= s_tuser;
      s1_wbit <= s_tdata[ADDR_W];
      s1_idx  <= in_addr[CELL_INDEX_BITS-1:0];
      s1_rid  <= row_id(in_addr);
    end
  end

  assign s1_pair_addr = s1_idx[CELL_INDEX_BITS-1:1];

  // cell pairs: one entry holds a cell and its neighbor
  assign cell_we    = clearing || s1_fire;
  assign cell_waddr = clearing ? clr_cnt[PAIR_BITS-1:0] : s1_pair_addr;
  assign cell_wdata = clearing ? 2'b00 : res.pair;

  dcfi_ram #(
    .WIDTH (2),
    .DEPTH (1 << PAIR_BITS)
  ) u_cell_ram (
    .clk   (clk),
    .we    (cell_we),
    .waddr (cell_waddr),
    .wdata (cell_wdata),
    .re    (in_req),
    .raddr (in_addr[CELL_INDEX_BITS-1:1]),
    .rdata (cell_rdata)
  );

  // row activation counters
  assign row_we    = clearing || s1_fire;
  assign row_waddr = clearing ? clr_cnt[ROW_ID_BITS-1:0] : s1_rid;
  assign row_wdata = clearing ? '0 : res.cnt;

  dcfi_ram #(
    .WIDTH (CNT_W),
    .DEPTH (1 << ROW_ID_BITS)
  ) u_row_ram (
    .clk   (clk),
    .we    (row_we),
    .waddr (row_waddr),
    .wdata (row_wdata),
    .re    (in_req),
    .raddr (row_id(in_addr)),
    .rdata (row_rdata)
  );

  // last write forwarding covers a read taken on the write-back edge
  always_ff @(posedge clk) begin
    if (rst) begin
      cw_valid <= 1'b0;
      rw_valid <= 1'b0;
    end else if (s1_fire) begin
      cw_valid <= 1'b1;
      rw_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      cw_addr <= s1_pair_addr;
      cw_data <= res.pair;
      rw_addr <= s1_rid;
      rw_data <= res.cnt;
    end
  end

  assign pair_cur = (cw_valid && cw_addr == s1_pair_addr) ? cw_data : cell_rdata;
  assign cnt_cur  = (rw_valid && rw_addr == s1_rid) ? rw_data : row_rdata;

  assign acc.op   = s1_op;
  assign acc.wbit = s1_wbit;
  assign acc.sel  = s1_idx[0];

  dcfi_eval u_eval (
    .cfg   (cfg),
    .acc   (acc),
    .pair  (pair_cur),
    .cnt   (cnt_cur),
    .draws (draws),
    .res   (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s1_fire) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      m_tdata <= M_TDATA_W'(res.code);
    end
  end

  // no request taken while the stores are being cleared
  a_no_req_clearing: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !s_tready)
    else $error("request taken during clearing sweep");

  // the decide stage always sees a full set of draws
  a_draws_ready: assert property (@(posedge clk) disable iff (rst)
    s1_valid |-> win_count >= WIN_CNT_W'(DRAW_MAX))
    else $error("draw window short while deciding");

  // every decision consumes at least one and at most the worst-case draws
  a_pop_range: assert property (@(posedge clk) disable iff (rst)
    s1_fire |-> (res.pops != '0) && (res.pops <= POP_W'(DRAW_MAX)))
    else $error("draw count out of range");

endmodule

// File: hdl/dcfi_ram.sv
module dcfi_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hdl/dcfi_rng.sv
module dcfi_rng import dcfi_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  rng_ctl_t             ctl,
  output draws_t               draws,
  output logic [WIN_CNT_W-1:0] win_count
);

  localparam int LVL_W = WIN_CNT_W + 1;

  logic [SEED_W-1:0]  lfsr;
  logic [SEED_W-1:0]  gen_st [GEN_LANES];
  logic               fire;
  logic [LVL_W-1:0]   level;

  // three-stage reduction per lane
  logic               a_v, b_v, c_v;
  logic [SEED_W-1:0]  a_x  [GEN_LANES];
  logic [PROD_W-1:0]  a_prod [GEN_LANES];
  logic [PPM_Y_W-1:0] b_y  [GEN_LANES];
  logic [PPM_Q_W-1:0] b_q  [GEN_LANES];
  logic [PPM_LO-1:0]  b_lo [GEN_LANES];
  logic [PPM_R_W-1:0] c_r0 [GEN_LANES];
  logic [PPM_LO-1:0]  c_lo [GEN_LANES];

  logic [GEN_LANES*PPM_W-1:0] push_vec;
  logic [WIN_W-1:0]           win_vec, win_next, shifted, keep_mask, push_ext;
  logic [WIN_CNT_W-1:0]       keep;

  // next states of the generator
  always_comb begin
    gen_st[0] = lfsr_step(lfsr);
    for (int l = 1; l < GEN_LANES; l++) begin
      gen_st[l] = lfsr_step(gen_st[l-1]);
    end
  end

  // credit: window plus values in flight must fit
  assign level = LVL_W'(win_count)
               + LVL_W'(GEN_LANES) * (LVL_W'(a_v) + LVL_W'(b_v) + LVL_W'(c_v));
  assign fire  = !ctl.load && (level + LVL_W'(GEN_LANES) <= LVL_W'(WIN_DEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      lfsr      <= SEED_W'(1);
      a_v       <= 1'b0;
      b_v       <= 1'b0;
      c_v       <= 1'b0;
      win_count <= '0;
    end else if (ctl.load) begin
      lfsr      <= (ctl.seed == '0) ? SEED_W'(1) : ctl.seed;
      a_v       <= 1'b0;
      b_v       <= 1'b0;
      c_v       <= 1'b0;
      win_count <= '0;
    end else begin
      if (fire) begin
        lfsr <= gen_st[GEN_LANES-1];
      end
      a_v       <= fire;
      b_v       <= a_v;
      c_v       <= b_v;
      win_count <= win_count - WIN_CNT_W'(ctl.pops)
                 + (c_v ? WIN_CNT_W'(GEN_LANES) : '0);
    end
  end

  // quotient estimate by reciprocal; low error means one correction step
  always_comb begin
    for (int l = 0; l < GEN_LANES; l++) begin
      a_prod[l] = PROD_W'(a_x[l][SEED_W-1:PPM_LO]) * PROD_W'(PPM_RECIP);
    end
  end

  always_ff @(posedge clk) begin
    for (int l = 0; l < GEN_LANES; l++) begin
      a_x[l]  <= gen_st[l];
      b_y[l]  <= a_x[l][SEED_W-1:PPM_LO];
      b_lo[l] <= a_x[l][PPM_LO-1:0];
      b_q[l]  <= PPM_Q_W'(a_prod[l] >> RECIP_SHIFT);
      c_r0[l] <= PPM_R_W'(b_y[l] - PPM_Y_W'(PPM_Y_W'(b_q[l]) * PPM_Y_W'(PPM_ODD)));
      c_lo[l] <= b_lo[l];
    end
    win_vec <= win_next;
  end

  // final correction and repack as r * 64 + low bits
  always_comb begin
    logic [PPM_R_W-1:0] r;
    for (int l = 0; l < GEN_LANES; l++) begin
      r = (c_r0[l] >= PPM_R_W'(PPM_ODD)) ? c_r0[l] - PPM_R_W'(PPM_ODD) : c_r0[l];
      push_vec[l*PPM_W +: PPM_W] = {r[PPM_R_W-2:0], c_lo[l]};
    end
  end

  // window: drop consumed values from the bottom, append new ones above the rest
  always_comb begin
    keep      = win_count - WIN_CNT_W'(ctl.pops);
    shifted   = win_vec >> (SH_W'(ctl.pops) * SH_W'(PPM_W));
    keep_mask = ~({WIN_W{1'b1}} << (SH_W'(keep) * SH_W'(PPM_W)));
    push_ext  = c_v ? (WIN_W'(push_vec) << (SH_W'(keep) * SH_W'(PPM_W))) : '0;
    win_next  = (shifted & keep_mask) | push_ext;
  end

  always_comb begin
    for (int k = 0; k < DRAW_MAX; k++) begin
      draws[k] = win_vec[k*PPM_W +: PPM_W];
    end
  end

endmodule

// File: hdl/dcfi_eval.sv
module dcfi_eval import dcfi_pkg::*; (
  input  cfg_t             cfg,
  input  access_t          acc,
  input  logic [1:0]       pair,
  input  logic [CNT_W-1:0] cnt,
  input  draws_t           draws,
  output result_t          res
);

  logic [DRAW_MAX-1:0] lt_c;

  // coupling compare on every slot, picked by position below
  always_comb begin
    for (int k = 0; k < DRAW_MAX; k++) begin
      lt_c[k] = draws[k] < cfg.p_coupling;
    end
  end

  always_comb begin
    logic             cur, agg, cell_n, nb_n, hit;
    logic [2:0]       pos;
    logic [CNT_W-1:0] inc;
    cur      = acc.sel ? pair[1] : pair[0];
    agg      = acc.sel ? pair[0] : pair[1];
    cell_n   = cur;
    nb_n     = agg;
    hit      = 1'b0;
    pos      = 3'd1;
    inc      = (cnt != CNT_MAX) ? cnt + CNT_W'(1) : cnt;
    res.code = FLT_NONE;
    res.cnt  = cnt;

    if (draws[0] < cfg.p_stuck) begin
      // stuck: the next draw's low bit lands in the cell
      res.code = FLT_STUCK;
      cell_n   = draws[1][0];
      hit      = 1'b1;
      pos      = 3'd2;
    end else if (!acc.op) begin
      if (draws[1] < cfg.p_read_dest) begin
        res.code = FLT_READ_DEST;
        cell_n   = ~cur;
        hit      = 1'b1;
        pos      = 3'd2;
      end else if (draws[2] < cfg.p_deceptive) begin
        // deceptive read flips the cell but reports nothing
        cell_n = ~cur;
        hit    = 1'b1;
        pos    = 3'd3;
      end else if (draws[3] < cfg.p_incorrect) begin
        res.code = FLT_INCORRECT;
        hit      = 1'b1;
        pos      = 3'd4;
      end else begin
        pos = 3'd4;
      end
    end else begin
      if (cur == acc.wbit) begin
        pos = 3'd2;
        if (draws[1] < cfg.p_write_dest) begin
          res.code = FLT_WRITE_DEST;
          cell_n   = ~acc.wbit;
          hit      = 1'b1;
        end
      end else begin
        if (agg && !cur && acc.wbit) begin
          pos = 3'd2;
          if (lt_c[1]) begin
            res.code = FLT_TRANSITION;
            cell_n   = 1'b0;
            hit      = 1'b1;
          end
        end
        if (!hit) begin
          if (lt_c[pos]) begin
            res.code = FLT_IDEMPOTENT;
            nb_n     = ~agg;
            hit      = 1'b1;
          end
          pos = pos + 3'd1;
        end
      end
    end

    // static coupling
    if (!hit && agg) begin
      if (lt_c[pos]) begin
        res.code = FLT_STATIC;
        cell_n   = 1'b0;
        hit      = 1'b1;
      end
      pos = pos + 3'd1;
    end

    // disturb coupling
    if (!hit) begin
      if (lt_c[pos]) begin
        res.code = FLT_DISTURB;
        nb_n     = ~agg;
        hit      = 1'b1;
      end
      pos = pos + 3'd1;
    end

    // row hammer, then the plain write
    if (!hit) begin
      if (inc > cfg.hammer_thr) begin
        res.code = FLT_HAMMER;
        res.cnt  = '0;
      end else begin
        res.cnt = inc;
        if (acc.op) begin
          cell_n = acc.wbit;
        end
      end
    end

    res.pops = POP_W'(pos);
    res.pair = acc.sel ? {cell_n, nb_n} : {nb_n, cell_n};
  end

endmodule
